@@ rtl/mdx_pkg.sv @@
// Package for the MIPS32 decode/execute unit: item types, opcode and funct
// codes, and memory access kind codes. Depends on nothing.
package mdx_pkg;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc_plus4;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_enable;
    logic [4:0]  write_reg;
    logic        redirect;
    logic [31:0] redirect_target;
    logic [2:0]  mem_kind;
    logic [31:0] mem_address;
    logic        unsupported;
  } out_item_t;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_LL    = 6'h30;

  // R-type funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Memory access kinds
  localparam logic [2:0] MEM_NONE = 3'd0;
  localparam logic [2:0] MEM_LW   = 3'd1;
  localparam logic [2:0] MEM_LBU  = 3'd2;
  localparam logic [2:0] MEM_LHU  = 3'd3;
  localparam logic [2:0] MEM_SW   = 3'd4;
  localparam logic [2:0] MEM_SB   = 3'd5;
  localparam logic [2:0] MEM_SH   = 3'd6;
  localparam logic [2:0] MEM_LL   = 3'd7;

  localparam logic [4:0] LINK_REG = 5'd31;

endpackage

@@ rtl/mdx_in_if.sv @@
// Instruction channel: valid/ready handshake carrying one instruction item.
// Depends on mdx_pkg.
interface mdx_in_if;
  import mdx_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/mdx_out_if.sv @@
// Result channel: valid/ready handshake carrying one execute result item.
// Depends on mdx_pkg.
interface mdx_out_if;
  import mdx_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/mips_decode_execute_unit_top.sv @@
// MIPS32 decode/execute unit: input register, decode/ALU logic, result register.
// Throughput: one item per cycle; both stages advance together when the result register
// is empty or its item is taken. A waiting result stalls intake once stage 1 is full.
// Reset (rst, synchronous, active high) empties both stages; payload is not cleared.
// Depends on mdx_pkg, mdx_in_if and mdx_out_if.
module mips_decode_execute_unit_top (
  input  logic      clk,
  input  logic      rst,
  mdx_in_if.sink    instr_ch,
  mdx_out_if.source result_ch
);
  import mdx_pkg::*;

  // Stage 1: captured instruction item
  logic      s1_valid;
  in_item_t  s1_item;

  // Stage 2: result register facing the sink
  logic      s2_valid;
  out_item_t s2_item;

  out_item_t exec_next;

  logic s2_free;
  logic s1_free;

  // The result register can load when empty or when its item leaves this cycle.
  assign s2_free        = !s2_valid || result_ch.ready;
  // Stage 1 moves into stage 2 whenever stage 2 can load.
  assign s1_free        = !s1_valid || s2_free;
  assign instr_ch.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= instr_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && instr_ch.valid) begin
      s1_item <= instr_ch.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_item <= exec_next;
    end
  end

  assign result_ch.valid = s2_valid;
  assign result_ch.item  = s2_item;

  // Decode fields
  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] pc4;
  logic [31:0] jtarget;
  logic [31:0] btarget;
  logic [31:0] eaddr;

  assign op   = s1_item.instruction[31:26];
  assign rt   = s1_item.instruction[20:16];
  assign rd   = s1_item.instruction[15:11];
  assign sh   = s1_item.instruction[10:6];
  assign fn   = s1_item.instruction[5:0];
  assign imm  = {16'h0000, s1_item.instruction[15:0]};
  assign simm = {{16{s1_item.instruction[15]}}, s1_item.instruction[15:0]};
  assign a    = s1_item.rs_value;
  assign b    = s1_item.rt_value;
  assign pc4  = s1_item.pc_plus4;

  // Jumps keep the upper four bits of PC+4; branches offset by the word immediate.
  assign jtarget = {pc4[31:28], s1_item.instruction[25:0], 2'b00};
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign eaddr   = a + simm;

  always_comb begin
    logic bad;
    bad       = 1'b0;
    exec_next = '0;

    if (op == OP_RTYPE) begin
      exec_next.write_reg    = rd;
      exec_next.write_enable = 1'b1;
      unique case (fn)
        FN_ADD, FN_ADDU: exec_next.result = a + b;
        FN_SUB, FN_SUBU: exec_next.result = a - b;
        FN_AND:  exec_next.result = a & b;
        FN_OR:   exec_next.result = a | b;
        FN_NOR:  exec_next.result = ~(a | b);
        FN_SLT:  exec_next.result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: exec_next.result = {31'd0, a < b};
        FN_SLL:  exec_next.result = b << sh;
        FN_SRL:  exec_next.result = b >> sh;
        FN_JR: begin
          exec_next.write_enable    = 1'b0;
          exec_next.write_reg       = '0;
          exec_next.redirect        = 1'b1;
          exec_next.redirect_target = a;
        end
        default: bad = 1'b1;
      endcase
    end else begin
      unique case (op)
        OP_J: begin
          exec_next.redirect        = 1'b1;
          exec_next.redirect_target = jtarget;
        end
        OP_JAL: begin
          exec_next.redirect        = 1'b1;
          exec_next.redirect_target = jtarget;
          exec_next.result          = pc4 + 32'd4;
          exec_next.write_enable    = 1'b1;
          exec_next.write_reg       = LINK_REG;
        end
        OP_BEQ: begin
          if (a == b) begin
            exec_next.redirect        = 1'b1;
            exec_next.redirect_target = btarget;
          end
        end
        OP_BNE: begin
          if (a != b) begin
            exec_next.redirect        = 1'b1;
            exec_next.redirect_target = btarget;
          end
        end
        OP_ADDI, OP_ADDIU: begin
          exec_next.result       = eaddr;
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        OP_SLTI: begin
          exec_next.result       = {31'd0, $signed(a) < $signed(simm)};
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        OP_SLTIU: begin
          exec_next.result       = {31'd0, a < simm};
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        OP_ANDI: begin
          exec_next.result       = a & imm;
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        OP_ORI: begin
          exec_next.result       = a | imm;
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        OP_LUI: begin
          exec_next.result       = {imm[15:0], 16'h0000};
          exec_next.write_enable = 1'b1;
          exec_next.write_reg    = rt;
        end
        // Loads name rt as destination; the memory stage does the write.
        OP_LW: begin
          exec_next.mem_kind  = MEM_LW;
          exec_next.write_reg = rt;
        end
        OP_LBU: begin
          exec_next.mem_kind  = MEM_LBU;
          exec_next.write_reg = rt;
        end
        OP_LHU: begin
          exec_next.mem_kind  = MEM_LHU;
          exec_next.write_reg = rt;
        end
        OP_LL: begin
          exec_next.mem_kind  = MEM_LL;
          exec_next.write_reg = rt;
        end
        OP_SW: exec_next.mem_kind = MEM_SW;
        OP_SB: exec_next.mem_kind = MEM_SB;
        OP_SH: exec_next.mem_kind = MEM_SH;
        default: bad = 1'b1;
      endcase
      if (exec_next.mem_kind != MEM_NONE) begin
        exec_next.mem_address = eaddr;
        exec_next.result      = eaddr;
      end
    end

    // Drop everything for sc and unknown codes, raise the flag alone.
    if (bad) begin
      exec_next             = '0;
      exec_next.unsupported = 1'b1;
    end
  end

`ifndef SYNTHESIS
  // An unsupported item carries no other information.
  assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.item.unsupported) |->
      (result_ch.item.result == 32'd0 && !result_ch.item.write_enable &&
       !result_ch.item.redirect && result_ch.item.mem_kind == MEM_NONE))
    else $error("unsupported item has nonzero fields");

  // Memory accesses report the effective address as result as well.
  assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.item.mem_kind != MEM_NONE) |->
      (result_ch.item.mem_address == result_ch.item.result &&
       !result_ch.item.write_enable))
    else $error("memory item address mismatch");

  // Target is zero unless redirecting.
  assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && !result_ch.item.redirect) |->
      (result_ch.item.redirect_target == 32'd0))
    else $error("target set without redirect");

  // Only jal both writes and redirects, always to the link register.
  assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.item.redirect && result_ch.item.write_enable) |->
      (result_ch.item.write_reg == LINK_REG))
    else $error("redirect with write to non-link register");

  // A stalled stage-1 item must not be lost.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_free) |=> (s1_valid && $stable(s1_item)))
    else $error("stage 1 item lost under stall");
`endif

endmodule
